// ===== src/fcd_pkg.sv =====
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants of the float constant divider
// Field widths, transaction structs, cell control and state encoding.
// ----------------------------------------------------------------------------
package fcd_pkg;

  localparam int MANT_W     = 64;
  localparam int EXP_W      = 32;
  localparam int FLAG_W     = 8;
  localparam int SIZE_W     = 8;
  localparam int NEG_BIT    = 0;
  localparam int CELL_W_DEF = 8;

  typedef struct packed {
    logic [MANT_W-1:0]       a_mant;
    logic signed [EXP_W-1:0] a_exp;
    logic [FLAG_W-1:0]       a_flags;
    logic [SIZE_W-1:0]       a_size;
    logic [MANT_W-1:0]       b_mant;
    logic signed [EXP_W-1:0] b_exp;
    logic [FLAG_W-1:0]       b_flags;
    logic [SIZE_W-1:0]       b_size;
  } fcd_in_t;

  typedef struct packed {
    logic [MANT_W-1:0]       q_mant;
    logic signed [EXP_W-1:0] q_exp;
    logic [FLAG_W-1:0]       q_flags;
    logic [SIZE_W-1:0]       q_size;
    logic                    error;
  } fcd_out_t;

  // control broadcast to every cell of the remainder/divisor row
  typedef struct packed {
    logic load;       // take operands from the input transaction
    logic take;       // keep the difference instead of the remainder
    logic rem_shift;  // shift the remainder one place up
    logic div_shift;  // shift the divisor one place down
  } fcd_cell_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PRE1 = 5'b00010,
    ST_PRE2 = 5'b00100,
    ST_RUN  = 5'b01000,
    ST_FIN  = 5'b10000
  } fcd_state_e;

endpackage

// ===== src/fcd_cell.sv =====
// ----------------------------------------------------------------------------
// fcd_cell: one slice of the remainder and divisor registers
// Subtracts its divisor slice with a rippled borrow and passes shifted bits
// to its neighbors.
// ----------------------------------------------------------------------------
module fcd_cell
  import fcd_pkg::*;
#(
  parameter int CellW = CELL_W_DEF
) (
  input  logic                 clk_i,
  input  fcd_cell_ctrl_t       ctrl_i,
  input  logic [CellW-1:0]     rem_ld_i,
  input  logic [CellW-1:0]     div_ld_i,
  input  logic                 borrow_i,
  output logic                 borrow_o,
  input  logic                 rem_lsb_i,
  output logic                 rem_msb_o,
  input  logic                 div_msb_i,
  output logic                 div_lsb_o,
  output logic [CellW-1:0]     rem_o
);

  logic [CellW-1:0] rem_q, rem_d;
  logic [CellW-1:0] div_q, div_d;
  logic [CellW-1:0] diff;
  logic [CellW-1:0] base;

  assign {borrow_o, diff} = {1'b0, rem_q} - {1'b0, div_q} - {{CellW{1'b0}}, borrow_i};

  assign base      = ctrl_i.take ? diff : rem_q;
  assign rem_msb_o = base[CellW-1];
  assign div_lsb_o = div_q[0];
  assign rem_o     = rem_q;

  always_comb begin
    if (ctrl_i.load) begin
      rem_d = rem_ld_i;
    end else if (ctrl_i.rem_shift) begin
      rem_d = {base[CellW-2:0], rem_lsb_i};
    end else begin
      rem_d = base;
    end
  end

  always_comb begin
    if (ctrl_i.load) begin
      div_d = div_ld_i;
    end else if (ctrl_i.div_shift) begin
      div_d = {div_msb_i, div_q[CellW-1:1]};
    end else begin
      div_d = div_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
  end

endmodule

// ===== src/float_const_divider_top.sv =====
// ----------------------------------------------------------------------------
// float_const_divider_top: restoring divider for 64-bit mantissa floats
// Row of subtract cells producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid_i/in_ready_o carry one fcd_in_t transaction (operands a, b);
//   out_valid_o/out_ready_i carry one fcd_out_t transaction per input.
//   in_ready_o is high while no division is in progress, so one operand
//   pair is worked on at a time.
//   A normal division runs the alignment step ST_PRE1 and, if the divisor
//   exceeds the dividend, ST_PRE2, then the restoring loop in ST_RUN,
//   one quotient bit per cycle through the borrow chain of the cell
//   row, then ST_FIN writes the output register once it is free.
//   Error cases and a zero dividend skip the loop; their result is
//   written from ST_FIN once the output register is free.
//   A new transaction is accepted only in ST_IDLE, which follows each
//   result, so a division starts only after the previous one has ended.
//   A new transaction may be accepted while the previous result still waits
//   in the output register; a finished division holds in its last state
//   until the output register is free.
//   Reset clears the control state and the output valid; no transaction is
//   pending afterwards.
// ----------------------------------------------------------------------------
module float_const_divider_top
  import fcd_pkg::*;
#(
  parameter int CellW = CELL_W_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fcd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fcd_out_t out_data_o
);

  localparam int NumCells = MANT_W / CellW;
  localparam int CntW     = $clog2(MANT_W - 1);
  localparam logic [CntW-1:0] RunLast = CntW'(MANT_W - 2);

  fcd_state_e state_q, state_d;

  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [MANT_W-1:0]       quo_q, quo_d;
  logic signed [EXP_W-1:0] exp_q, exp_d;
  logic signed [EXP_W-1:0] aexp_q, aexp_d;
  logic [FLAG_W-1:0]       flags_q, flags_d;
  logic [SIZE_W-1:0]       size_q, size_d;
  logic                    err_q, err_d;
  logic                    zero_q, zero_d;
  logic                    out_valid_q, out_valid_d;
  fcd_out_t                out_q, out_d;

  fcd_cell_ctrl_t          ctrl;
  logic                    in_acc;
  logic                    ge;
  logic                    out_free;
  logic [MANT_W-1:0]       rem_all;
  logic [NumCells:0]       borrow;
  logic [NumCells:0]       rem_chain;
  logic [NumCells:0]       div_chain;
  logic                    a_neg, b_neg;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign ge          = !borrow[NumCells];
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign borrow[0]           = 1'b0;
  assign rem_chain[0]        = 1'b0;
  assign div_chain[NumCells] = 1'b0;

  // row of cells, cell 0 holds the low bits
  for (genvar gi = 0; gi < NumCells; gi++) begin : g_cell
    fcd_cell #(
      .CellW (CellW)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .rem_ld_i  (in_data_i.a_mant[gi*CellW +: CellW]),
      .div_ld_i  (in_data_i.b_mant[gi*CellW +: CellW]),
      .borrow_i  (borrow[gi]),
      .borrow_o  (borrow[gi+1]),
      .rem_lsb_i (rem_chain[gi]),
      .rem_msb_o (rem_chain[gi+1]),
      .div_msb_i (div_chain[gi+1]),
      .div_lsb_o (div_chain[gi]),
      .rem_o     (rem_all[gi*CellW +: CellW])
    );
  end

  assign a_neg = in_data_i.a_flags[NEG_BIT];
  assign b_neg = in_data_i.b_flags[NEG_BIT];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    exp_d       = exp_q;
    aexp_d      = aexp_q;
    flags_d     = flags_q;
    size_d      = size_q;
    err_d       = err_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ctrl        = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.load         = 1'b1;
          quo_d             = MANT_W'(1);
          exp_d             = in_data_i.a_exp - in_data_i.b_exp;
          aexp_d            = in_data_i.a_exp;
          flags_d           = in_data_i.a_flags;
          flags_d[NEG_BIT]  = a_neg ^ b_neg;
          size_d            = (in_data_i.a_size > in_data_i.b_size) ?
                              in_data_i.a_size : in_data_i.b_size;
          err_d             = !in_data_i.b_mant[MANT_W-1] ||
                              ((in_data_i.a_mant != '0) && !in_data_i.a_mant[MANT_W-1]);
          zero_d            = (in_data_i.a_mant == '0);
          state_d           = (err_d || zero_d) ? ST_FIN : ST_PRE1;
        end
      end
      ST_PRE1: begin
        // leading step: subtract the divisor if it fits and halve it; else lower the exponent
        ctrl.take      = ge;
        ctrl.div_shift = 1'b1;
        if (ge) begin
          cnt_d   = RunLast;
          state_d = ST_RUN;
        end else begin
          exp_d   = exp_q - EXP_W'(1);
          state_d = ST_PRE2;
        end
      end
      ST_PRE2: begin
        ctrl.take      = 1'b1;
        ctrl.div_shift = 1'b1;
        cnt_d          = RunLast;
        state_d        = ST_RUN;
      end
      ST_RUN: begin
        ctrl.take      = ge;
        ctrl.rem_shift = 1'b1;
        quo_d          = {quo_q[MANT_W-2:0], ge};
        cnt_d          = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.q_flags = flags_q;
          out_d.q_size  = size_q;
          out_d.error   = err_q;
          if (err_q) begin
            out_d.q_mant = rem_all;  // cells still hold a_mant
            out_d.q_exp  = aexp_q;
          end else if (zero_q) begin
            out_d.q_mant = '0;
            out_d.q_exp  = '0;
          end else begin
            out_d.q_mant = quo_q;
            out_d.q_exp  = exp_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    quo_q   <= quo_d;
    exp_q   <= exp_d;
    aexp_q  <= aexp_d;
    flags_q <= flags_d;
    size_q  <= size_d;
    err_q   <= err_d;
    zero_q  <= zero_d;
    out_q   <= out_d;
  end

  // dividend is at least half the divisor, so the second alignment never borrows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRE2) |-> ge)
    else $error("borrow in second alignment step");

  // a normal quotient keeps its leading one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.error && (out_data_o.q_mant != '0))
      |-> out_data_o.q_mant[MANT_W-1])
    else $error("quotient lost its leading one");

  // the output register is never overwritten while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("pending result overwritten");

  // leaving the loop only after the last quotient bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && (cnt_q != '0)) |=> (state_q == ST_RUN))
    else $error("division loop ended early");

endmodule
